// ----- rtl/cbm_pkg.sv -----
// Shared types and constants of the cartridge bank mapper.
`default_nettype none

package cbm_pkg;

  localparam int SLOT_COUNT    = 64;
  localparam int SLOT_W        = $clog2(SLOT_COUNT);
  localparam int MAX_ROM_PAGES = 256;
  localparam int PAGE_W        = 12;
  localparam int MASK_W        = 5;

  typedef enum logic [1:0] {
    RG_ROM  = 2'd0,
    RG_CRAM = 2'd1,
    RG_WRAM = 2'd2,
    RG_NONE = 2'd3
  } region_t;

  localparam logic [2:0] KIND_NONE      = 3'd0;
  localparam logic [2:0] KIND_STD       = 3'd1;
  localparam logic [2:0] KIND_TRIO      = 3'd2;
  localparam logic [2:0] KIND_KOREAN    = 3'd3;
  localparam logic [2:0] KIND_KOREAN8K  = 3'd4;
  localparam logic [2:0] KIND_FOUR_PACK = 3'd5;

  localparam logic [1:0] CFG_MAPPER_KIND  = 2'd0;
  localparam logic [1:0] CFG_ROM_PAGES    = 2'd1;
  localparam logic [1:0] CFG_OFFSET_QUIRK = 2'd2;

  localparam logic [1:0] PREG_CTRL  = 2'd0;
  localparam logic [1:0] PREG_BANK0 = 2'd1;
  localparam logic [1:0] PREG_BANK1 = 2'd2;
  localparam logic [1:0] PREG_BANK2 = 2'd3;

  typedef enum logic [2:0] {
    ST_BASE,
    ST_IDLE,
    ST_RD,
    ST_OUT,
    ST_MLOAD,
    ST_MITER,
    ST_FILL
  } state_t;

  typedef struct packed {
    region_t             region;
    logic [PAGE_W-1:0]   page;
  } slot_entry_t;

  typedef struct packed {
    logic                en;
    logic [SLOT_W-1:0]   first;
    logic [SLOT_W-1:0]   last;
    region_t             region;
    logic [PAGE_W-1:0]   base;
    logic [MASK_W-1:0]   mask;
  } fill_op_t;

endpackage

`default_nettype wire

// ----- rtl/cbm_if.sv -----
// Request and response channel interfaces of the cartridge bank mapper.
`default_nettype none

interface cbm_req_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [15:0] cpu_address;
  logic [7:0]  write_data;

  modport source (output valid, command, cpu_address, write_data, input ready);
  modport sink   (input valid, command, cpu_address, write_data, output ready);
endinterface

interface cbm_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  target_region;
  logic [21:0] physical_address;
  logic        store_enable;
  logic        paging_hit;
  logic        backup_ram_used;

  modport source (output valid, target_region, physical_address, store_enable, paging_hit,
                  backup_ram_used, input ready);
  modport sink   (input valid, target_region, physical_address, store_enable, paging_hit,
                  backup_ram_used, output ready);
endinterface

`default_nettype wire

// ----- rtl/cartridge_bank_mapper.sv -----
// Cartridge bank mapper: translates CPU accesses through a 64-entry 1K slot map.
//
// The req channel carries one CPU access per transfer (command, cpu_address,
// write_data); the rsp channel returns one translation per access. Both use
// valid/ready. Configuration is a plain write port (cfg_write, cfg_index,
// cfg_data); the user must see that it is written only while no access is
// outstanding, as the block itself does not enforce this. An ordinary read
// or write issues the read of the single-port slot map, registers its data,
// then loads the output register. A paging write first runs four remainder
// steps (one for the 8K kind) on a shared one-bit-per-cycle unit, then
// rewrites up to 32 slots at one slot a cycle, then looks the address up.
// req.ready is high only between accesses. Reset, and a write of mapper_kind
// or rom_pages, sweeps all 64 slots with the base map and then replays the
// four default paging writes; no access is taken meanwhile. The result waits
// in an output register while the receiver stalls; a new access may be
// taken meanwhile, and its result is held back until the register is free.
`default_nettype none

module cartridge_bank_mapper
  import cbm_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  cbm_req_if.sink      req,
  cbm_rsp_if.source    rsp,
  input  wire logic    cfg_write,
  input  wire logic [1:0] cfg_index,
  input  wire logic [8:0] cfg_data
);

  localparam logic [3:0]  MOD_LAST  = 4'd8;
  localparam logic [MASK_W-1:0] MASK16 = 5'h0F;
  localparam logic [MASK_W-1:0] MASK8  = 5'h07;
  localparam logic [8:0]  PAGES_MAX = 9'(MAX_ROM_PAGES);

  // Configuration
  logic [2:0] mapper_kind;
  logic [8:0] rom_pages;
  logic       offset_quirk_off;

  // Sequencer and datapath registers
  state_t     state, state_next;
  logic [7:0] preg [4];
  logic       backup_flag;
  logic       def_active;
  logic [1:0] def_reg;
  logic       cmd_q;
  logic [15:0] addr_q;
  logic [7:0] data_q;
  logic [1:0] reg_q;
  logic       hit_q;
  logic       pass_q;
  logic       is8k_q;
  logic [1:0] mstep;
  logic [3:0] mcnt;
  logic [8:0] mdiv;
  logic [8:0] mrem;
  logic [8:0] bank_a;
  logic [8:0] bank_b;
  logic [SLOT_W-1:0] fslot;
  logic       fidx;
  slot_entry_t rd_entry;

  // Output register
  logic        out_valid;
  region_t     out_region;
  logic [21:0] out_phys;
  logic        out_store;
  logic        out_hit;
  logic        out_backup;

  // Slot map memory
  slot_entry_t slot_map [SLOT_COUNT];
  logic              mem_we;
  logic [SLOT_W-1:0] mem_waddr;
  slot_entry_t       mem_wdata;

  logic [2:0] kind_eff;
  logic [8:0] np_eff;
  logic [9:0] divisor;
  logic [9:0] trial;
  logic [8:0] mrem_next;
  logic [8:0] mod_src;
  logic       accept;
  logic       load_out;
  logic       cfg_remap;
  logic       set_backup;
  logic       hit_dec;
  logic       pass_dec;
  logic [1:0] reg_dec;
  logic [7:0] data_dec;
  fill_op_t   op0, op1, cur_op;
  logic       op_done;

  function automatic logic [4:0] bank_skew(input logic [1:0] ctl);
    logic [4:0] r;
    if (ctl == 2'd0) r = 5'd0;
    else             r = {2'(3'd4 - {1'b0, ctl}), 3'b000};
    return r;
  endfunction

  // Effective configuration
  always_comb begin
    kind_eff = (mapper_kind > KIND_FOUR_PACK) ? KIND_STD : mapper_kind;
    if (rom_pages == 9'd0)           np_eff = 9'd1;
    else if (rom_pages > PAGES_MAX)  np_eff = PAGES_MAX;
    else                             np_eff = rom_pages;
    divisor = is8k_q ? {np_eff, 1'b0} : {1'b0, np_eff};
  end

  // Remainder unit: one dividend bit per cycle
  always_comb begin
    trial = {mrem, mdiv[8]};
    if (trial >= divisor) mrem_next = 9'(trial - divisor);
    else                  mrem_next = trial[8:0];
  end

  always_comb begin
    case (mstep)
      2'd0:    mod_src = {1'b0, data_q};
      2'd1:    mod_src = 9'(bank_a + (offset_quirk_off ? 5'd0 : bank_skew(preg[0][1:0])));
      2'd2:    mod_src = {1'b0, preg[3]};
      default: mod_src = 9'(bank_b + ((reg_q == PREG_CTRL) ? bank_skew(data_q[1:0]) : 5'd0));
    endcase
  end

  // Decode of paging addresses for the accepted access
  always_comb begin
    hit_dec  = 1'b0;
    reg_dec  = PREG_CTRL;
    data_dec = req.write_data;
    if (req.command) begin
      case (kind_eff)
        KIND_NONE: ;
        KIND_STD: begin
          if (req.cpu_address >= 16'hFFFC) begin
            hit_dec = 1'b1;
            reg_dec = req.cpu_address[1:0];
          end
        end
        KIND_TRIO: begin
          if (req.cpu_address == 16'h0000) begin
            hit_dec = 1'b1;
            reg_dec = PREG_BANK0;
          end else if (req.cpu_address == 16'h4000) begin
            hit_dec = 1'b1;
            reg_dec = PREG_BANK1;
          end else if (req.cpu_address == 16'h8000) begin
            hit_dec = 1'b1;
            reg_dec = PREG_BANK2;
          end
        end
        KIND_KOREAN: begin
          if (req.cpu_address == 16'hA000) begin
            hit_dec = 1'b1;
            reg_dec = PREG_BANK2;
          end
        end
        KIND_KOREAN8K: begin
          if (req.cpu_address <= 16'h0003) begin
            hit_dec = 1'b1;
            reg_dec = req.cpu_address[1:0];
          end
        end
        default: begin
          if (req.cpu_address == 16'h3FFE) begin
            hit_dec = 1'b1;
            reg_dec = PREG_BANK0;
          end else if (req.cpu_address == 16'h7FFF) begin
            hit_dec = 1'b1;
            reg_dec = PREG_BANK1;
          end else if (req.cpu_address == 16'hBFFF) begin
            hit_dec  = 1'b1;
            reg_dec  = PREG_BANK2;
            data_dec = 8'((preg[1] & 8'h30) + req.write_data);
          end
        end
      endcase
    end
    pass_dec = (kind_eff == KIND_NONE) || (kind_eff == KIND_STD) || !hit_dec;
  end

  // Slot ranges rewritten by the current paging write
  always_comb begin
    op0 = '0;
    op1 = '0;
    if (is8k_q) begin
      op0.en = 1'b1;
      case (reg_q)
        PREG_CTRL:  op0.first = 6'h20;
        PREG_BANK0: op0.first = 6'h28;
        PREG_BANK1: op0.first = 6'h10;
        default:    op0.first = 6'h18;
      endcase
      op0.last   = 6'(op0.first + 6'd7);
      op0.region = RG_ROM;
      op0.base   = {bank_a, 3'b000};
      op0.mask   = MASK8;
    end else begin
      case (reg_q)
        PREG_CTRL: begin
          op0.en    = 1'b1;
          op0.first = 6'h20;
          op0.last  = 6'h2F;
          op0.mask  = MASK16;
          if (data_q[3]) begin
            op0.region = RG_CRAM;
            op0.base   = data_q[2] ? 12'd16 : 12'd0;
          end else begin
            op0.region = RG_ROM;
            op0.base   = {bank_b[7:0], 4'b0000};
          end
          op1.en    = 1'b1;
          op1.first = 6'h30;
          op1.last  = 6'h3F;
          op1.base  = '0;
          if (data_q[4]) begin
            op1.region = RG_CRAM;
            op1.mask   = MASK16;
          end else begin
            op1.region = RG_WRAM;
            op1.mask   = MASK8;
          end
        end
        PREG_BANK0: begin
          op0.en     = 1'b1;
          op0.first  = (kind_eff == KIND_TRIO || kind_eff == KIND_FOUR_PACK) ? 6'h00 : 6'h01;
          op0.last   = 6'h0F;
          op0.region = RG_ROM;
          op0.base   = {bank_a[7:0], 4'b0000};
          op0.mask   = MASK16;
        end
        PREG_BANK1: begin
          op0.en     = 1'b1;
          op0.first  = 6'h10;
          op0.last   = 6'h1F;
          op0.region = RG_ROM;
          op0.base   = {bank_a[7:0], 4'b0000};
          op0.mask   = MASK16;
          op1.en     = (kind_eff == KIND_TRIO);
          op1.first  = 6'h28;
          op1.last   = 6'h2F;
          op1.mask   = MASK16;
          if (data_q[7]) begin
            op1.region = RG_CRAM;
            op1.base   = '0;
          end else begin
            op1.region = RG_ROM;
            op1.base   = {bank_b[7:0], 4'b0000};
          end
        end
        default: begin
          // A mapped cartridge RAM window keeps the upper ROM window untouched.
          op0.en     = !preg[0][3];
          op0.first  = 6'h20;
          op0.last   = 6'h27;
          op0.region = RG_ROM;
          op0.base   = {bank_a[7:0], 4'b0000};
          op0.mask   = MASK16;
          op1.en     = !preg[0][3] && !(kind_eff == KIND_TRIO && preg[2][7]);
          op1.first  = 6'h28;
          op1.last   = 6'h2F;
          op1.region = RG_ROM;
          op1.base   = {bank_a[7:0], 4'b0000};
          op1.mask   = MASK16;
        end
      endcase
    end
    cur_op  = fidx ? op1 : op0;
    op_done = !cur_op.en || (fslot == cur_op.last);
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_BASE: begin
        if (fslot == 6'h3F) state_next = ST_MLOAD;
      end
      ST_IDLE: begin
        if (accept) state_next = hit_dec ? ST_MLOAD : ST_RD;
      end
      ST_RD:    state_next = ST_OUT;
      ST_OUT: begin
        if (load_out) state_next = ST_IDLE;
      end
      ST_MLOAD: state_next = ST_MITER;
      ST_MITER: begin
        if (mcnt == MOD_LAST) begin
          state_next = (is8k_q || mstep == 2'd3) ? ST_FILL : ST_MLOAD;
        end
      end
      ST_FILL: begin
        if (op_done && fidx) begin
          if (!def_active)          state_next = ST_RD;
          else if (def_reg == 2'd3) state_next = ST_IDLE;
          else                      state_next = ST_MLOAD;
        end
      end
      default: state_next = ST_BASE;
    endcase
    if (cfg_remap) state_next = ST_BASE;
  end

  // Control outputs
  always_comb begin
    req.ready  = (state == ST_IDLE);
    accept     = (state == ST_IDLE) && req.valid;
    load_out   = (state == ST_OUT) && (!out_valid || rsp.ready);
    cfg_remap  = cfg_write && (cfg_index == CFG_MAPPER_KIND || cfg_index == CFG_ROM_PAGES);
    mem_we     = 1'b0;
    mem_waddr  = fslot;
    mem_wdata  = '0;
    set_backup = 1'b0;
    case (state)
      ST_BASE: begin
        mem_we = 1'b1;
        if (fslot < 6'h30) begin
          mem_wdata.region = RG_ROM;
          mem_wdata.page   = {7'd0, fslot[4:0]};
        end else begin
          mem_wdata.region = RG_WRAM;
          mem_wdata.page   = {9'd0, fslot[2:0]};
        end
      end
      ST_FILL: begin
        mem_we           = cur_op.en;
        mem_wdata.region = cur_op.region;
        mem_wdata.page   = cur_op.base | {7'd0, fslot[4:0] & cur_op.mask};
        set_backup       = cur_op.en && (cur_op.region == RG_CRAM);
      end
      default: ;
    endcase
  end

  // Slot map: one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) slot_map[mem_waddr] <= mem_wdata;
    if (state == ST_RD) rd_entry <= slot_map[addr_q[15:10]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_BASE;
      mapper_kind      <= KIND_STD;
      rom_pages        <= 9'd32;
      offset_quirk_off <= 1'b0;
      backup_flag      <= 1'b0;
      def_active       <= 1'b1;
      fslot            <= '0;
      out_valid        <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_write) begin
        case (cfg_index)
          CFG_MAPPER_KIND:  mapper_kind      <= cfg_data[2:0];
          CFG_ROM_PAGES:    rom_pages        <= cfg_data;
          CFG_OFFSET_QUIRK: offset_quirk_off <= cfg_data[0];
          default: ;
        endcase
      end

      if (set_backup) backup_flag <= 1'b1;

      if (load_out) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;

      if (cfg_remap) begin
        fslot      <= '0;
        def_active <= 1'b1;
      end else begin
        case (state)
          ST_BASE: begin
            fslot <= 6'(fslot + 6'd1);
            if (fslot == 6'h3F) begin
              // Base map done: load the default paging registers and replay them.
              preg[0] <= 8'd0;
              preg[1] <= 8'd0;
              preg[2] <= 8'd1;
              preg[3] <= (kind_eff <= KIND_STD) ? 8'd2 : 8'd0;
              def_reg <= 2'd0;
              reg_q   <= PREG_CTRL;
              data_q  <= 8'd0;
              is8k_q  <= (kind_eff == KIND_KOREAN8K);
              mstep   <= 2'd0;
            end
          end
          ST_IDLE: begin
            if (accept) begin
              cmd_q  <= req.command;
              addr_q <= req.cpu_address;
              data_q <= data_dec;
              reg_q  <= reg_dec;
              hit_q  <= hit_dec;
              pass_q <= pass_dec;
              is8k_q <= (kind_eff == KIND_KOREAN8K);
              mstep  <= 2'd0;
            end
          end
          ST_MLOAD: begin
            mdiv <= mod_src;
            mrem <= '0;
            mcnt <= '0;
          end
          ST_MITER: begin
            mrem <= mrem_next;
            mdiv <= {mdiv[7:0], 1'b0};
            mcnt <= 4'(mcnt + 4'd1);
            if (mcnt == MOD_LAST) begin
              if (mstep[1]) bank_b <= mrem_next;
              else          bank_a <= mrem_next;
              mstep <= 2'(mstep + 2'd1);
              if (is8k_q || mstep == 2'd3) begin
                preg[reg_q] <= data_q;
                fidx        <= 1'b0;
                fslot       <= op0.first;
              end
            end
          end
          ST_FILL: begin
            if (op_done) begin
              if (!fidx) begin
                fidx  <= 1'b1;
                fslot <= op1.first;
              end else if (def_active) begin
                if (def_reg == 2'd3) begin
                  def_active <= 1'b0;
                end else begin
                  def_reg <= 2'(def_reg + 2'd1);
                  reg_q   <= 2'(def_reg + 2'd1);
                  data_q  <= preg[2'(def_reg + 2'd1)];
                  mstep   <= 2'd0;
                end
              end
            end else begin
              fslot <= 6'(fslot + 6'd1);
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_hit    <= hit_q;
      out_backup <= backup_flag;
      if (!cmd_q || (pass_q && rd_entry.region != RG_ROM)) begin
        out_region <= rd_entry.region;
        out_phys   <= {rd_entry.page, addr_q[9:0]};
        out_store  <= cmd_q;
      end else begin
        out_region <= RG_NONE;
        out_phys   <= '0;
        out_store  <= 1'b0;
      end
    end
  end

  assign rsp.valid            = out_valid;
  assign rsp.target_region    = out_region;
  assign rsp.physical_address = out_phys;
  assign rsp.store_enable     = out_store;
  assign rsp.paging_hit       = out_hit;
  assign rsp.backup_ram_used  = out_backup;

`ifndef SYNTHESIS
  a_mod_range: assert property (@(posedge clk) disable iff (rst)
      (state == ST_MITER && mcnt == MOD_LAST) |-> ({1'b0, mrem_next} < divisor))
    else $error("bank remainder not below the divisor");

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
      (state == ST_FILL && cur_op.en) |-> (fslot >= cur_op.first && fslot <= cur_op.last))
    else $error("slot rewrite outside its window");

  a_store_region: assert property (@(posedge clk) disable iff (rst)
      (out_valid && out_store) |-> (out_region == RG_CRAM || out_region == RG_WRAM))
    else $error("store flagged for a region that takes no writes");
`endif

endmodule

`default_nettype wire
